// ===== design/ctlv_pkg.sv =====
// Shared types and constants for the capability TLV parser.
`timescale 1ns / 1ps
package ctlv_pkg;

   typedef enum logic [1:0] {
      PHASE_CATEGORY = 2'd0,
      PHASE_LENGTH   = 2'd1,
      PHASE_VALUE    = 2'd2,
      PHASE_SKIP     = 2'd3
   } phase_type;

   localparam logic [7:0] INVALID_CATEGORY = 8'hFF;
   localparam logic [7:0] MAX_LEN_RESET    = 8'd62;
   localparam int unsigned CSR_ADDR_WIDTH  = 3;
   localparam logic        CSR_IDX_MAX_LEN = 1'b0;

   typedef struct packed {
      logic       record_valid;
      logic [7:0] category_id;
      logic [7:0] value_length;
      logic [7:0] value_index;
      logic [7:0] value_byte;
      logic       has_value;
      logic       last_of_record;
      logic       message_done;
   } result_type;

   typedef struct packed {
      logic       accept;
      logic [7:0] data_byte;
      logic       byte_present;
      logic       restart;
      logic       end_of_message;
   } item_type;

endpackage

// ===== design/ctlv_req_if.sv =====
// Request channel interface: payload byte with boundary flags.
`timescale 1ns / 1ps
interface ctlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       restart;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output restart, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input restart, input end_of_message, output ready);
endinterface

// ===== design/ctlv_rsp_if.sv =====
// Response channel interface: one record byte or boundary result.
`timescale 1ns / 1ps
interface ctlv_rsp_if;
   logic       valid;
   logic       ready;
   logic       record_valid;
   logic [7:0] category_id;
   logic [7:0] value_length;
   logic [7:0] value_index;
   logic [7:0] value_byte;
   logic       has_value;
   logic       last_of_record;
   logic       message_done;

   modport source (output valid, output record_valid, output category_id,
                   output value_length, output value_index, output value_byte,
                   output has_value, output last_of_record, output message_done,
                   input ready);
   modport sink   (input valid, input record_valid, input category_id,
                   input value_length, input value_index, input value_byte,
                   input has_value, input last_of_record, input message_done,
                   output ready);
endinterface

// ===== design/capability_tlv_parser_unit.sv =====
// Top level of the capability TLV parser: register port, parser and result buffer.
//
// Requests arrive on req_if, one payload byte each, with restart and
// end_of_message flags; byte_present low makes a boundary-only request.
// Results leave on rsp_if: one per value byte of an accepted record, one for
// a zero-length record, one with message_done at end of message; requests
// that cause none give no result. Records longer than max_value_length
// (register 0, reset 62) are skipped to their end.
// A result is registered into the buffer at the edge that accepts its request.
// Throughput: one request per cycle while req_if.ready is high; the parser
// state updates at the accept edge and results land in a two-entry buffer.
// When rsp_if stalls, one further result is held in the skid slot, then
// req_if.ready drops until the head is taken.
// Reset (synchronous) empties the buffer, returns the parser to expect a
// category byte and restores the register default.
`timescale 1ns / 1ps
module capability_tlv_parser_unit
   import ctlv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   ctlv_req_if.sink                  req_if,
   ctlv_rsp_if.source                rsp_if
);

   logic       max_len_sel;
   logic [7:0] max_len_val_ff;
   logic       csr_write;
   logic       buf_full;
   logic       head_valid;
   logic       res_push;
   item_type   item;
   result_type res;
   result_type head;

   assign pready      = 1'b1;
   assign csr_write   = psel && penable && pwrite;
   assign max_len_sel = paddr[2] == CSR_IDX_MAX_LEN;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_val_ff <= MAX_LEN_RESET;
      end else if (csr_write && max_len_sel) begin
         max_len_val_ff <= pwdata[7:0];
      end
   end

   assign prdata = max_len_sel ? {24'd0, max_len_val_ff} : 32'd0;

   assign req_if.ready = !buf_full;
   assign item         = {req_if.valid && !buf_full, req_if.data_byte, req_if.byte_present,
                          req_if.restart, req_if.end_of_message};

   ctlv_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .max_len  (max_len_val_ff),
      .res_push (res_push),
      .res      (res)
   );

   ctlv_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_push),
      .push_data  (res),
      .pop        (rsp_if.valid && rsp_if.ready),
      .head_valid (head_valid),
      .head_data  (head),
      .full       (buf_full)
   );

   assign rsp_if.valid          = head_valid;
   assign rsp_if.record_valid   = head.record_valid;
   assign rsp_if.category_id    = head.category_id;
   assign rsp_if.value_length   = head.value_length;
   assign rsp_if.value_index    = head.value_index;
   assign rsp_if.value_byte     = head.value_byte;
   assign rsp_if.has_value      = head.has_value;
   assign rsp_if.last_of_record = head.last_of_record;
   assign rsp_if.message_done   = head.message_done;

`ifndef SYNTH
   a_eom_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && req_if.end_of_message |=> rsp_if.valid)
      else $error("end of message request left no result");

   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid)
      else $error("request stalled with empty result head");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && max_len_sel |=> max_len_val_ff == $past(pwdata[7:0]))
      else $error("limit register write lost");
`endif

endmodule

// ===== design/ctlv_parser.sv =====
// Parser state and per-byte decode of category, length and value.
`timescale 1ns / 1ps
module ctlv_parser
   import ctlv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic [7:0] max_len,
   output logic       res_push,
   output result_type res
);

   phase_type  phase_ff, phase_in;
   logic [7:0] cat_ff, cat_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] off_ff, off_in;

   always_comb begin
      phase_type  p;
      logic [7:0] c;
      logic [7:0] l;
      logic [7:0] o;
      logic [7:0] o_next;
      logic       have;
      result_type r;

      p      = item.restart ? PHASE_CATEGORY : phase_ff;
      c      = item.restart ? INVALID_CATEGORY : cat_ff;
      l      = item.restart ? 8'd0 : len_ff;
      o      = item.restart ? 8'd0 : off_ff;
      o_next = 8'(o + 8'd1);
      have   = 1'b0;
      r      = '0;

      if (item.byte_present) begin
         unique case (p)
            PHASE_CATEGORY: begin
               c = item.data_byte;
               p = PHASE_LENGTH;
            end
            PHASE_LENGTH: begin
               o = 8'd0;
               l = item.data_byte;
               if (item.data_byte > max_len) begin
                  p = PHASE_SKIP;
               end else if (item.data_byte == 8'd0) begin
                  have             = 1'b1;
                  r.record_valid   = 1'b1;
                  r.category_id    = c;
                  r.last_of_record = 1'b1;
                  p                = PHASE_CATEGORY;
                  c                = INVALID_CATEGORY;
               end else begin
                  p = PHASE_VALUE;
               end
            end
            PHASE_VALUE: begin
               have           = 1'b1;
               r.record_valid = 1'b1;
               r.category_id  = c;
               r.value_length = l;
               r.value_index  = o;
               r.value_byte   = item.data_byte;
               r.has_value    = 1'b1;
               o              = o_next;
               if (o_next == l) begin
                  r.last_of_record = 1'b1;
                  p                = PHASE_CATEGORY;
                  c                = INVALID_CATEGORY;
               end
            end
            PHASE_SKIP: begin
               o = o_next;
               if (o_next == l) begin
                  p = PHASE_CATEGORY;
                  c = INVALID_CATEGORY;
               end
            end
            default: p = PHASE_CATEGORY;
         endcase
      end

      if (item.end_of_message) begin
         p              = PHASE_CATEGORY;
         c              = INVALID_CATEGORY;
         l              = 8'd0;
         o              = 8'd0;
         have           = 1'b1;
         r.message_done = 1'b1;
      end

      phase_in = p;
      cat_in   = c;
      len_in   = l;
      off_in   = o;
      res      = r;
      res_push = item.accept && have;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_CATEGORY;
         cat_ff   <= INVALID_CATEGORY;
         len_ff   <= 8'd0;
         off_ff   <= 8'd0;
      end else if (item.accept) begin
         phase_ff <= phase_in;
         cat_ff   <= cat_in;
         len_ff   <= len_in;
         off_ff   <= off_in;
      end
   end

endmodule

// ===== design/ctlv_out_buf.sv =====
// Two-entry result buffer: head register plus skid slot.
`timescale 1ns / 1ps
module ctlv_out_buf
   import ctlv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop,
   output logic       head_valid,
   output result_type head_data,
   output logic       full
);

   logic       v0_ff, v0_in;
   logic       v1_ff, v1_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;

   always_comb begin
      v0_in   = v0_ff;
      v1_in   = v1_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      if (pop && v1_ff) begin
         head_in = skid_ff;
         v1_in   = 1'b0;
      end else if (pop) begin
         v0_in   = push;
         head_in = push_data;
      end else if (push) begin
         if (!v0_ff) begin
            v0_in   = 1'b1;
            head_in = push_data;
         end else begin
            v1_in   = 1'b1;
            skid_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign head_valid = v0_ff;
   assign head_data  = head_ff;
   assign full       = v1_ff;

endmodule
